// ===== rtl/ccbp_pkg.sv =====
//==============================================================================
// ccbp_pkg
// Shared types and constants for the coil command byte parser.
//==============================================================================
`default_nettype none

package ccbp_pkg;

   localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
   localparam logic [6:0]  MAG_MAX    = 7'd100;
   localparam logic [15:0] LEVEL_STEP = 16'd300;
   localparam logic [14:0] LEVEL_FULL = 15'd29999;

   localparam logic [16:0] SCALE_SECS  = 17'd1;
   localparam logic [16:0] SCALE_MINS  = 17'd60;
   localparam logic [16:0] SCALE_HOURS = 17'd3600;
   localparam logic [16:0] SCALE_DAYS  = 17'd86400;

   localparam logic [1:0] TS_SECS  = 2'd0;
   localparam logic [1:0] TS_MINS  = 2'd1;
   localparam logic [1:0] TS_HOURS = 2'd2;
   localparam logic [1:0] TS_DAYS  = 2'd3;

   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_CW  = 2'd1;
   localparam logic [1:0] DIR_CCW = 2'd2;

   localparam logic [1:0] MODE_LOW = 2'd0;
   localparam logic [1:0] MODE_ON  = 2'd1;
   localparam logic [1:0] MODE_PWM = 2'd2;

   localparam logic [1:0] CSR_ECHO     = 2'd0;
   localparam logic [1:0] CSR_COIL     = 2'd1;
   localparam logic [1:0] CSR_TIMED    = 2'd2;
   localparam logic [1:0] CSR_PERIODIC = 2'd3;

   localparam logic [2:0] ECHO_RST     = 3'd1;
   localparam logic [2:0] COIL_RST     = 3'd2;
   localparam logic [2:0] TIMED_RST    = 3'd3;
   localparam logic [2:0] PERIODIC_RST = 3'd4;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_INTENSITY,
      PH_ON_HI,
      PH_ON_LO,
      PH_PER_HI,
      PH_PER_LO
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_IDLE,
      K_ECHO,
      K_CLEAR,
      K_DRIVE,
      K_ON,
      K_PER
   } kind_type;

   typedef struct packed {
      logic [2:0] echo_code;
      logic [2:0] coil_code;
      logic [2:0] timed_code;
      logic [2:0] periodic_code;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [2:0] cmask;
      logic [7:0] high;
      logic [1:0] scale;
   } s1_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [2:0]  cmask;
      logic [1:0]  dir;
      logic [14:0] level;
      logic [1:0]  mode;
      logic [32:0] tval;
   } s2_type;

   typedef struct packed {
      logic        reply_valid;
      logic [7:0]  reply_byte;
      logic        clear_timers;
      logic [2:0]  coil_mask;
      logic        set_drive;
      logic [1:0]  coil_direction;
      logic [14:0] drive_level;
      logic [1:0]  drive_mode;
      logic        set_time_on;
      logic [32:0] time_on_secs;
      logic        set_period;
      logic [32:0] period_secs;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/coil_command_byte_parser.sv =====
//==============================================================================
// coil_command_byte_parser
// Parses serial bytes into coil drive, on-time and period commands.
//==============================================================================
// Usage:
//   req_ channel carries one received byte per word (req_rx_byte); every
//   accepted byte yields exactly one rsp_ word, in order. A first byte of
//   0xFF replies idle, an echo opcode echoes, any other clears the coil timers
//   and one at or above the coil opcode starts a multi-byte command. The user
//   writes four 3-bit opcode registers via csr_ only while idle; unenforced.
// Pipeline: an accepted byte passes the parse register, the multiply register
//   and the output register in order before rsp_valid rises.
// Throughput: one byte per cycle; each stage holds one word and takes a new
//   one whenever its successor moves or it is empty, so req_ready stays high
//   while downstream bubbles remain even if rsp_ready is low.
// Stall: with rsp_ready low the output word is held; upstream stages fill,
//   then req_ready drops.
// Reset: synchronous; empties the pipeline, returns parsing to the first
//   byte, clears held command state and loads the opcode defaults.
//==============================================================================
`default_nettype none

module coil_command_byte_parser import ccbp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [2:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_reply_valid,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_clear_timers,
   output logic [2:0]       rsp_coil_mask,
   output logic             rsp_set_drive,
   output logic [1:0]       rsp_coil_direction,
   output logic [14:0]      rsp_drive_level,
   output logic [1:0]       rsp_drive_mode,
   output logic             rsp_set_time_on,
   output logic [32:0]      rsp_time_on_secs,
   output logic             rsp_set_period,
   output logic [32:0]      rsp_period_secs
);

   cfg_type cfg_ff, cfg_in;
   logic    s1_valid, s1_ready;
   s1_type  s1_item;
   logic    s2_valid, s2_ready;
   s2_type  s2_item;
   rsp_type word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ECHO:     cfg_in.echo_code     = csr_wdata;
            CSR_COIL:     cfg_in.coil_code     = csr_wdata;
            CSR_TIMED:    cfg_in.timed_code    = csr_wdata;
            CSR_PERIODIC: cfg_in.periodic_code = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_code     <= ECHO_RST;
         cfg_ff.coil_code     <= COIL_RST;
         cfg_ff.timed_code    <= TIMED_RST;
         cfg_ff.periodic_code <= PERIODIC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccbp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_rx_byte),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   ccbp_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_item  (s2_item)
   );

   ccbp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_item   (s2_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (word)
   );

   assign rsp_reply_valid    = word.reply_valid;
   assign rsp_reply_byte     = word.reply_byte;
   assign rsp_clear_timers   = word.clear_timers;
   assign rsp_coil_mask      = word.coil_mask;
   assign rsp_set_drive      = word.set_drive;
   assign rsp_coil_direction = word.coil_direction;
   assign rsp_drive_level    = word.drive_level;
   assign rsp_drive_mode     = word.drive_mode;
   assign rsp_set_time_on    = word.set_time_on;
   assign rsp_time_on_secs   = word.time_on_secs;
   assign rsp_set_period     = word.set_period;
   assign rsp_period_secs    = word.period_secs;

endmodule

`default_nettype wire

// ===== rtl/ccbp_parse.sv =====
//==============================================================================
// ccbp_parse
// Command framing state machine and input register stage.
//==============================================================================
`default_nettype none

module ccbp_parse import ccbp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire logic [7:0] in_byte,
   output logic        out_valid,
   input  wire logic   out_ready,
   output s1_type      out_item
);

   phase_type  phase_ff, phase_in;
   logic [7:0] command_ff, command_in;
   logic [1:0] scale_ff, scale_in;
   logic [7:0] high_ff, high_in;
   logic       valid_ff, valid_in;
   s1_type     item_ff, item_in;
   logic       accept;
   logic [2:0] top;
   logic [2:0] btop;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign top      = command_ff[7:5];
   assign btop     = in_byte[7:5];

   always_comb begin
      phase_in   = phase_ff;
      command_in = command_ff;
      scale_in   = scale_ff;
      high_in    = high_ff;
      if (accept) begin
         case (phase_ff)
            PH_INTENSITY: begin
               if (top >= cfg.timed_code) begin
                  scale_in = in_byte[1:0];
                  phase_in = PH_ON_HI;
               end else begin
                  phase_in = PH_FIRST;
               end
            end
            PH_ON_HI: begin
               high_in  = in_byte;
               phase_in = PH_ON_LO;
            end
            PH_PER_HI: begin
               high_in  = in_byte;
               phase_in = PH_PER_LO;
            end
            PH_ON_LO: begin
               phase_in = (top == cfg.periodic_code) ? PH_PER_HI : PH_FIRST;
            end
            PH_PER_LO: begin
               phase_in = PH_FIRST;
            end
            default: begin
               phase_in   = PH_FIRST;
               command_in = in_byte;
               if (in_byte != IDLE_BYTE && btop != cfg.echo_code && btop >= cfg.coil_code)
                  phase_in = PH_INTENSITY;
            end
         endcase
      end
   end

   always_comb begin
      item_in       = item_ff;
      valid_in      = valid_ff;
      if (accept) begin
         valid_in      = 1'b1;
         item_in.data  = in_byte;
         item_in.cmask = command_ff[4:2];
         item_in.high  = high_ff;
         item_in.scale = scale_ff;
         case (phase_ff)
            PH_INTENSITY: item_in.kind = K_DRIVE;
            PH_ON_HI:     item_in.kind = K_NONE;
            PH_PER_HI:    item_in.kind = K_NONE;
            PH_ON_LO:     item_in.kind = K_ON;
            PH_PER_LO:    item_in.kind = K_PER;
            default: begin
               if (in_byte == IDLE_BYTE)
                  item_in.kind = K_IDLE;
               else if (btop == cfg.echo_code)
                  item_in.kind = K_ECHO;
               else
                  item_in.kind = K_CLEAR;
            end
         endcase
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         command_ff <= '0;
         scale_ff   <= '0;
         high_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         command_ff <= command_in;
         scale_ff   <= scale_in;
         high_ff    <= high_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/ccbp_calc.sv =====
//==============================================================================
// ccbp_calc
// Intensity to drive level conversion and time scaling multiply stage.
//==============================================================================
`default_nettype none

module ccbp_calc import ccbp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire s1_type in_item,
   output logic        out_valid,
   input  wire logic   out_ready,
   output s2_type      out_item
);

   logic        valid_ff, valid_in;
   s2_type      item_ff, item_in;
   logic [8:0]  neg;
   logic [7:0]  mag_raw;
   logic [6:0]  mag;
   logic [15:0] lvl_prod;
   logic [16:0] factor;
   logic [15:0] tword;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      neg      = 9'd256 - {1'b0, in_item.data};
      mag_raw  = in_item.data[7] ? neg[7:0] : in_item.data;
      mag      = (mag_raw > {1'b0, MAG_MAX}) ? MAG_MAX : mag_raw[6:0];
      lvl_prod = 16'(mag) * LEVEL_STEP - 16'd1;
      tword    = {in_item.high, in_item.data};
      case (in_item.scale)
         TS_SECS:  factor = SCALE_SECS;
         TS_MINS:  factor = SCALE_MINS;
         TS_HOURS: factor = SCALE_HOURS;
         TS_DAYS:  factor = SCALE_DAYS;
         default:  factor = SCALE_SECS;
      endcase
   end

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in      = 1'b1;
         item_in.kind  = in_item.kind;
         item_in.data  = in_item.data;
         item_in.cmask = in_item.cmask;
         if (in_item.data[7])
            item_in.dir = DIR_CCW;
         else if (in_item.data == 8'd0)
            item_in.dir = DIR_OFF;
         else
            item_in.dir = DIR_CW;
         item_in.level = (mag == 7'd0) ? 15'd0 : lvl_prod[14:0];
         if (mag == 7'd0)
            item_in.mode = MODE_LOW;
         else if (mag == MAG_MAX)
            item_in.mode = MODE_ON;
         else
            item_in.mode = MODE_PWM;
         item_in.tval = 33'(tword) * 33'(factor);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/ccbp_out.sv =====
//==============================================================================
// ccbp_out
// Period check against the last on-time and result output register.
//==============================================================================
`default_nettype none

module ccbp_out import ccbp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire s2_type in_item,
   output logic        out_valid,
   input  wire logic   out_ready,
   output rsp_type     out_word
);

   logic        valid_ff, valid_in;
   rsp_type     word_ff, word_in;
   logic [32:0] last_on_ff, last_on_in;
   logic        accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      word_in    = word_ff;
      valid_in   = valid_ff;
      last_on_in = last_on_ff;
      if (accept) begin
         valid_in = 1'b1;
         word_in  = '0;
         case (in_item.kind)
            K_IDLE: begin
               word_in.reply_valid = 1'b1;
               word_in.reply_byte  = IDLE_BYTE;
            end
            K_ECHO: begin
               word_in.reply_valid = 1'b1;
               word_in.reply_byte  = in_item.data;
            end
            K_CLEAR: begin
               word_in.clear_timers = 1'b1;
            end
            K_DRIVE: begin
               word_in.coil_mask      = in_item.cmask;
               word_in.set_drive      = 1'b1;
               word_in.coil_direction = in_item.dir;
               word_in.drive_level    = in_item.level;
               word_in.drive_mode     = in_item.mode;
            end
            K_ON: begin
               word_in.coil_mask    = in_item.cmask;
               word_in.set_time_on  = 1'b1;
               word_in.time_on_secs = in_item.tval;
               last_on_in           = in_item.tval;
            end
            K_PER: begin
               if (in_item.tval > last_on_ff) begin
                  word_in.coil_mask   = in_item.cmask;
                  word_in.set_period  = 1'b1;
                  word_in.period_secs = in_item.tval;
               end
            end
            default: begin
               word_in = '0;
            end
         endcase
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         last_on_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         last_on_ff <= last_on_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ===== rtl/ccbp_checker.sv =====
//==============================================================================
// ccbp_checker
// Port-level checks for the coil command byte parser, bound to the top.
//==============================================================================
`default_nettype none

module ccbp_checker import ccbp_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_reply_valid,
   input wire logic [7:0]  rsp_reply_byte,
   input wire logic        rsp_clear_timers,
   input wire logic [2:0]  rsp_coil_mask,
   input wire logic        rsp_set_drive,
   input wire logic [1:0]  rsp_coil_direction,
   input wire logic [14:0] rsp_drive_level,
   input wire logic [1:0]  rsp_drive_mode,
   input wire logic        rsp_set_time_on,
   input wire logic [32:0] rsp_time_on_secs,
   input wire logic        rsp_set_period,
   input wire logic [32:0] rsp_period_secs
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_level)
         && $stable(rsp_time_on_secs) && $stable(rsp_period_secs)
         && $stable(rsp_reply_byte) && $stable(rsp_coil_mask))
      else $error("result word changed while stalled");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_reply_valid, rsp_clear_timers, rsp_set_drive,
                              rsp_set_time_on, rsp_set_period}))
      else $error("more than one action in a result word");

   a_mode_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_drive |->
         ((rsp_drive_mode == MODE_LOW) == (rsp_drive_level == 15'd0))
         && ((rsp_drive_mode == MODE_ON) == (rsp_drive_level == LEVEL_FULL))
         && ((rsp_coil_direction == DIR_OFF) == (rsp_drive_level == 15'd0)))
      else $error("drive mode, direction and level disagree");

   a_mask_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_set_drive && !rsp_set_time_on && !rsp_set_period |->
         rsp_coil_mask == 3'd0 && rsp_drive_level == 15'd0
         && rsp_time_on_secs == 33'd0 && rsp_period_secs == 33'd0)
      else $error("coil fields set without a coil action");

endmodule

bind coil_command_byte_parser ccbp_checker u_ccbp_checker (.*);

`default_nettype wire

// ===== sim/tb_coil_command_byte_parser.sv =====
`timescale 1ns / 100ps
//==============================================================================
// tb_coil_command_byte_parser
// Self-checking bench for the coil command byte parser. A queue-fed driver
// offers serial bytes, a shadow parser predicts each reply word, and a monitor
// compares every word field by field. The bench runs several opcode register
// settings with random gaps and stalls on both channels, including a long
// receiver hold-off.
//==============================================================================

module tb_coil_command_byte_parser import ccbp_pkg::*;;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_ECHO;
   logic [2:0]  csr_wdata = 3'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_clear_timers;
   logic [2:0]  rsp_coil_mask;
   logic        rsp_set_drive;
   logic [1:0]  rsp_coil_direction;
   logic [14:0] rsp_drive_level;
   logic [1:0]  rsp_drive_mode;
   logic        rsp_set_time_on;
   logic [32:0] rsp_time_on_secs;
   logic        rsp_set_period;
   logic [32:0] rsp_period_secs;

   // shadow opcode registers
   logic [2:0]  code_echo = ECHO_RST;
   logic [2:0]  code_coil = COIL_RST;
   logic [2:0]  code_timed = TIMED_RST;
   logic [2:0]  code_periodic = PERIODIC_RST;

   // shadow parser state
   phase_type   pp_phase = PH_FIRST;
   logic [7:0]  pp_cmd = 8'h00;
   logic [1:0]  pp_scale = 2'd0;
   logic [7:0]  pp_high = 8'h00;
   logic [32:0] pp_on_time = 33'd0;

   logic [7:0]  rx_pending [$];
   rsp_type     expected_words [$];

   logic        no_gaps = 1'b0;
   int          stall_kick = 0;
   int          stall_ack = 0;
   int          stall_left = 0;
   int          gap_left = 0;
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          words_checked = 0;
   int          settings_run = 1;

   coil_command_byte_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_clear_timers   (rsp_clear_timers),
      .rsp_coil_mask      (rsp_coil_mask),
      .rsp_set_drive      (rsp_set_drive),
      .rsp_coil_direction (rsp_coil_direction),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_drive_mode     (rsp_drive_mode),
      .rsp_set_time_on    (rsp_set_time_on),
      .rsp_time_on_secs   (rsp_time_on_secs),
      .rsp_set_period     (rsp_set_period),
      .rsp_period_secs    (rsp_period_secs)
   );

   always #5 clock = ~clock;

   function automatic logic [32:0] scaled_secs(input logic [7:0] hi, input logic [7:0] lo);
      logic [32:0] t;
      t = {17'd0, hi, lo};
      case (pp_scale)
         TS_MINS:  t = t * 33'(SCALE_MINS);
         TS_HOURS: t = t * 33'(SCALE_HOURS);
         TS_DAYS:  t = t * 33'(SCALE_DAYS);
         default:  t = t * 33'(SCALE_SECS);
      endcase
      return t;
   endfunction

   function automatic rsp_type parse_byte(input logic [7:0] b);
      rsp_type     w;
      logic [2:0]  top;
      logic [2:0]  cm;
      int          mag;
      logic [14:0] lvl;
      logic [32:0] per;
      w = '0;
      top = pp_cmd[7:5];
      cm = pp_cmd[4:2];
      case (pp_phase)
         PH_INTENSITY: begin
            if (b[7]) begin
               mag = 256 - int'(b);
               w.coil_direction = DIR_CCW;
            end else if (b == 8'h00) begin
               mag = 0;
               w.coil_direction = DIR_OFF;
            end else begin
               mag = int'(b);
               w.coil_direction = DIR_CW;
            end
            if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
            lvl = (mag == 0) ? 15'd0 : 15'(mag * int'(LEVEL_STEP) - 1);
            w.coil_mask = cm;
            w.set_drive = 1'b1;
            w.drive_level = lvl;
            if (lvl == 15'd0) w.drive_mode = MODE_LOW;
            else if (lvl == LEVEL_FULL) w.drive_mode = MODE_ON;
            else w.drive_mode = MODE_PWM;
            if (top >= code_timed) begin
               pp_scale = b[1:0];
               pp_phase = PH_ON_HI;
            end else begin
               pp_phase = PH_FIRST;
            end
         end
         PH_ON_HI: begin
            pp_high = b;
            pp_phase = PH_ON_LO;
         end
         PH_PER_HI: begin
            pp_high = b;
            pp_phase = PH_PER_LO;
         end
         PH_ON_LO: begin
            pp_on_time = scaled_secs(pp_high, b);
            w.coil_mask = cm;
            w.set_time_on = 1'b1;
            w.time_on_secs = pp_on_time;
            if (top == code_periodic) pp_phase = PH_PER_HI;
            else pp_phase = PH_FIRST;
         end
         PH_PER_LO: begin
            per = scaled_secs(pp_high, b);
            if (per > pp_on_time) begin
               w.coil_mask = cm;
               w.set_period = 1'b1;
               w.period_secs = per;
            end
            pp_phase = PH_FIRST;
         end
         default: begin
            pp_phase = PH_FIRST;
            pp_cmd = b;
            if (b == IDLE_BYTE) begin
               w.reply_valid = 1'b1;
               w.reply_byte = IDLE_BYTE;
            end else if (b[7:5] == code_echo) begin
               w.reply_valid = 1'b1;
               w.reply_byte = b;
            end else begin
               w.clear_timers = 1'b1;
               if (b[7:5] >= code_coil) pp_phase = PH_INTENSITY;
            end
         end
      endcase
      return w;
   endfunction

   function automatic int idle_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_intensity();
      case ($urandom_range(0, 13))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h7F;
         3:       return 8'h80;
         4:       return 8'h64;
         5:       return 8'h9C;
         6:       return 8'h65;
         7:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report_error(input string msg);
      fail_count++;
      if (fail_count <= 20) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [32:0] got,
                              input logic [32:0] want);
      if (got !== want)
         report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   task automatic compare_word(input rsp_type want);
      check_field("reply_valid", 33'(rsp_reply_valid), 33'(want.reply_valid));
      check_field("reply_byte", 33'(rsp_reply_byte), 33'(want.reply_byte));
      check_field("clear_timers", 33'(rsp_clear_timers), 33'(want.clear_timers));
      check_field("coil_mask", 33'(rsp_coil_mask), 33'(want.coil_mask));
      check_field("set_drive", 33'(rsp_set_drive), 33'(want.set_drive));
      check_field("coil_direction", 33'(rsp_coil_direction), 33'(want.coil_direction));
      check_field("drive_level", 33'(rsp_drive_level), 33'(want.drive_level));
      check_field("drive_mode", 33'(rsp_drive_mode), 33'(want.drive_mode));
      check_field("set_time_on", 33'(rsp_set_time_on), 33'(want.set_time_on));
      check_field("time_on_secs", rsp_time_on_secs, want.time_on_secs);
      check_field("set_period", 33'(rsp_set_period), 33'(want.set_period));
      check_field("period_secs", rsp_period_secs, want.period_secs);
   endtask

   // track opcode register writes
   always @(posedge clock) begin
      if (reset) begin
         code_echo <= ECHO_RST;
         code_coil <= COIL_RST;
         code_timed <= TIMED_RST;
         code_periodic <= PERIODIC_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ECHO:     code_echo <= csr_wdata;
            CSR_COIL:     code_coil <= csr_wdata;
            CSR_TIMED:    code_timed <= csr_wdata;
            CSR_PERIODIC: code_periodic <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // driver: predict on acceptance, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         pp_phase = PH_FIRST;
         pp_cmd = 8'h00;
         pp_scale = 2'd0;
         pp_high = 8'h00;
         pp_on_time = 33'd0;
      end else begin
         if (req_valid && req_ready) begin
            expected_words.push_back(parse_byte(req_rx_byte));
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
               req_rx_byte <= rx_pending.pop_front();
               req_valid <= 1'b1;
               gap_left = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted words, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) report_error("reply word with nothing expected");
            else compare_word(expected_words.pop_front());
            words_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_kick != stall_ack) begin
            stall_ack = stall_kick;
            stall_left = 300;
            rsp_ready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 99) < 15) begin
            stall_left = idle_len();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (rx_pending.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_codes(input logic [2:0] e, input logic [2:0] c,
                                input logic [2:0] t, input logic [2:0] p);
      wait_drained();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_ECHO;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_COIL;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= CSR_TIMED;
      csr_wdata <= t;
      @(posedge clock);
      csr_index <= CSR_PERIODIC;
      csr_wdata <= p;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   // mostly well-formed commands with random content, some loose bytes
   task automatic queue_traffic(input int n_bytes);
      int         queued;
      logic [2:0] top;
      queued = 0;
      while (queued < n_bytes) begin
         if ($urandom_range(0, 99) < 78) begin
            top = 3'($urandom_range(int'(code_coil), 7));
            rx_pending.push_back({top, 5'($urandom)});
            rx_pending.push_back(pick_intensity());
            queued += 2;
            if (top >= code_timed) begin
               rx_pending.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
               rx_pending.push_back(8'($urandom));
               queued += 2;
               if (top == code_periodic) begin
                  rx_pending.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
                  rx_pending.push_back(8'($urandom));
                  queued += 2;
               end
            end
         end else begin
            rx_pending.push_back(($urandom_range(0, 3) == 0) ? IDLE_BYTE : 8'($urandom));
            queued++;
         end
      end
   endtask

   initial begin
      logic [7:0] directed_seq [25];
      directed_seq = '{8'hFF, 8'h20, 8'h00,
                       8'h5C, 8'h7F, 8'h44, 8'h80, 8'h48, 8'h00,
                       8'h7C, 8'hFF, 8'hFF, 8'hFF,
                       8'h9C, 8'h32, 8'h00, 8'h10, 8'h00, 8'h20,
                       8'h90, 8'h9D, 8'h00, 8'h05, 8'h00, 8'h05};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_seq[i]) rx_pending.push_back(directed_seq[i]);
      queue_traffic(220);

      program_codes(3'd0, 3'd0, 3'd0, 3'd0);
      queue_traffic(200);
      program_codes(3'd7, 3'd7, 3'd7, 3'd7);
      queue_traffic(100);
      program_codes(3'd0, 3'd1, 3'd1, 3'd1);
      queue_traffic(220);
      program_codes(3'd7, 3'd0, 3'd4, 3'd6);
      queue_traffic(220);

      // back-pressure: sender streams while the receiver holds off
      program_codes(3'd2, 3'd0, 3'd3, 3'd5);
      no_gaps <= 1'b1;
      stall_kick <= stall_kick + 1;
      queue_traffic(250);
      wait_drained();
      no_gaps <= 1'b0;

      program_codes(3'd5, 3'd2, 3'd2, 3'd3);
      no_gaps <= 1'b1;
      queue_traffic(200);
      wait_drained();
      no_gaps <= 1'b0;

      program_codes(3'($urandom), 3'($urandom_range(0, 3)), 3'($urandom), 3'($urandom));
      queue_traffic(200);
      program_codes(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
      queue_traffic(200);

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0) report_error("reply words still expected at end");
      $display("Parsed %0d bytes and checked %0d reply words over %0d opcode settings,",
               bytes_sent, words_checked, settings_run);
      $display("including a long receiver hold-off and gap-free bursts.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
